FILE: src/tdce_pkg.sv
// Shared types, constants and helpers for the toric defect cluster engine.
// No dependencies; every other file imports this package.
package tdce_pkg;

    localparam int MAX_W       = 32;
    localparam int MAX_H       = 32;
    localparam int MAX_DEFECTS = 32;
    localparam int SLOT_W      = $clog2(MAX_DEFECTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int COORD_W     = 5;
    localparam int DIM_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 48;

    localparam logic [2:0] CMD_TOGGLE  = 3'd0;
    localparam logic [2:0] CMD_MARK    = 3'd1;
    localparam logic [2:0] CMD_UNMARK  = 3'd2;
    localparam logic [2:0] CMD_CLEAR   = 3'd3;
    localparam logic [2:0] CMD_CLUSTER = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_H = 2'd1;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_MEMBER = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_FULL   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_CMD,
        RES_EMPTY,
        RES_MEMBER
    } res_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EXEC,
        ST_QCHECK,
        ST_SEED,
        ST_BFS,
        ST_SCAN,
        ST_RECT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     apply;
        logic     q_clear;
        logic     seed;
        logic     bfs_step;
        logic     scan_start;
        logic     scan_step;
        logic     rect_fin;
        logic     emit_step;
        logic     cid_inc;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_cluster;
        logic any_unmarked;
        logic any_seed;
        logic any_pending;
        logic scan_done;
        logic cur_member;
        logic cur_end;
    } dp_stat_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] member_x;
        logic [COORD_W-1:0] member_y;
        logic [4:0]         cluster_id;
        logic               cluster_end;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [DIM_W-1:0]   rect_w;
        logic [DIM_W-1:0]   rect_h;
        logic [CNT_W-1:0]   defect_count;
        logic               last;
    } result_t;

    // Lowest set bit of a slot vector (priority encoder).
    function automatic logic [SLOT_W-1:0] lowest_idx(input logic [MAX_DEFECTS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int k = MAX_DEFECTS - 1; k >= 0; k--) begin
            if (v[k]) r = SLOT_W'(k);
        end
        return r;
    endfunction

    // Grid dimension clamped to 1..limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (v > lim) r = lim;
        else r = v;
        return r;
    endfunction

endpackage

FILE: src/toric_defect_cluster_engine.sv
// Top level of the toric defect cluster engine: ports, output register.
// Depends on tdce_pkg, tdce_ctrl and tdce_dp.
//
// Usage:
//  - s_ channel: one request per handshake (toggle, mark, unmark all,
//    clear all, cluster). s_tready is high while the sequencer is idle,
//    even if a finished result still sits in the output register.
//  - m_ channel: result items from a one-deep output register; m_tlast
//    flags the final result of a request, m_tuser carries the kind.
//  - cfg_ channel: always ready; write grid width (index 0) or height
//    (index 1); any such write empties the defect list. Write only idle.
//  - Toggle/mark/unmark/clear: dispatch, then execute loads the result;
//    the next request is taken only once the sequencer is back in idle.
//  - Cluster: dispatch, then a check for unmarked defects (an empty query
//    answers there), then per cluster a seed step, a link-lane step per
//    member plus one, a span scan over every column and row, a rectangle
//    step and an emit step per list slot up to the cluster's last member.
//  - Reset empties the list, drops marks and sets the grid to 32 x 32.
//  - When m_tready is low while m_tvalid is high, the sequencer holds at the next result.
module toric_defect_cluster_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cmd[2:0], pos_x[7:3], pos_y[12:8], level[15:13]
    input  logic [tdce_pkg::IN_W-1:0]          s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // member_x[4:0], member_y[9:5], cluster_id[14:10], cluster_end[15],
    // rect_x[20:16], rect_y[25:21], rect_w[31:26], rect_h[37:32],
    // defect_count[43:38], zero[47:44]
    output logic [tdce_pkg::OUT_W-1:0]         m_tdata,
    // kind[1:0]
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tdce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdce_pkg::DIM_W-1:0]         cfg_data
);
    import tdce_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    result_t  dp_res;
    logic     out_free, out_load;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    tdce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    tdce_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_in    (dp_cmd),
        .stat      (dp_stat),
        .res       (dp_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_res_reg <= dp_res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {4'b0000, m_res_reg.defect_count, m_res_reg.rect_h,
                       m_res_reg.rect_w, m_res_reg.rect_y, m_res_reg.rect_x,
                       m_res_reg.cluster_end, m_res_reg.cluster_id,
                       m_res_reg.member_y, m_res_reg.member_x};

endmodule

FILE: src/tdce_ctrl.sv
// Sequencer for the toric defect cluster engine.
// Depends on tdce_pkg; drives tdce_dp through dp_cmd_t and reads dp_stat_t.
module tdce_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              out_free,
    output logic              out_load,
    input  tdce_pkg::dp_stat_t stat,
    output tdce_pkg::dp_cmd_t  cmd
);
    import tdce_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_CMD;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = stat.is_cluster ? ST_QCHECK : ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.apply  = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_QCHECK: begin
                cmd.res_sel = RES_EMPTY;
                if (!stat.any_unmarked) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.q_clear = 1'b1;
                    state_next  = ST_SEED;
                end
            end
            ST_SEED: begin
                cmd.seed   = 1'b1;
                state_next = ST_BFS;
            end
            ST_BFS: begin
                if (stat.any_pending) begin
                    cmd.bfs_step = 1'b1;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) state_next = ST_RECT;
            end
            ST_RECT: begin
                cmd.rect_fin = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.res_sel = RES_MEMBER;
                if (!stat.cur_member) begin
                    cmd.emit_step = 1'b1;
                end else if (out_free) begin
                    out_load      = 1'b1;
                    cmd.emit_step = 1'b1;
                    if (stat.cur_end) begin
                        if (stat.any_seed) begin
                            cmd.cid_inc = 1'b1;
                            state_next  = ST_SEED;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: src/tdce_dp.sv
// Datapath of the toric defect cluster engine: defect list, link lanes,
// span scan and result formation. Depends on tdce_pkg; steered by tdce_ctrl.
module tdce_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [tdce_pkg::IN_W-1:0]          in_data,
    input  logic                               cfg_valid,
    input  logic [tdce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdce_pkg::DIM_W-1:0]         cfg_data,
    input  tdce_pkg::dp_cmd_t                  cmd_in,
    output tdce_pkg::dp_stat_t                 stat,
    output tdce_pkg::result_t                  res
);
    import tdce_pkg::*;

    // configuration and request
    logic [DIM_W-1:0]   grid_w_reg, grid_h_reg;
    logic [2:0]         cmd_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [2:0]         lvl_reg;

    // defect list
    logic [CNT_W-1:0]       count_reg;
    logic [COORD_W-1:0]     pos_x_reg [MAX_DEFECTS];
    logic [COORD_W-1:0]     pos_y_reg [MAX_DEFECTS];
    logic [MAX_DEFECTS-1:0] marked_reg, visited_reg, pending_reg, member_reg;

    // query
    logic [4:0]        cid_reg;
    logic [SLOT_W-1:0] emit_idx_reg;
    logic [4:0]        scan_c_reg;
    logic [MAX_W-1:0]  occ_reg   [2];
    logic              fv_reg    [2];
    logic [4:0]        first_reg [2];
    logic [4:0]        prev_reg  [2];
    logic [4:0]        bgap_reg  [2];
    logic [4:0]        bstart_reg[2];
    logic [COORD_W-1:0] rect_x_reg, rect_y_reg;
    logic [DIM_W-1:0]   rect_w_reg, rect_h_reg;

    logic [DIM_W-1:0]       eff_w, eff_h;
    logic [MAX_DEFECTS-1:0] valid, hit, near, seeds, higher;
    logic                   on_grid, hit_any, full, cur_end;
    logic [SLOT_W-1:0]      hit_idx, last_idx, pend_idx, seed_idx, rd_addr;
    logic [COORD_W-1:0]     rd_x, rd_y;
    logic [CNT_W-1:0]       count_after;
    logic [7:0]             radius;
    logic [MAX_W-1:0]       col_occ, row_occ;
    logic [MAX_DEFECTS-1:0] marks_removed;

    assign eff_w   = clamp_dim(grid_w_reg, DIM_W'(MAX_W));
    assign eff_h   = clamp_dim(grid_h_reg, DIM_W'(MAX_H));
    assign on_grid = ({1'b0, px_reg} < eff_w) && ({1'b0, py_reg} < eff_h);
    assign radius  = 8'd1 << lvl_reg;
    assign full    = (count_reg == CNT_W'(MAX_DEFECTS));
    assign last_idx = SLOT_W'(count_reg - CNT_W'(1));

    always_comb begin
        for (int j = 0; j < MAX_DEFECTS; j++) begin
            valid[j] = (CNT_W'(j) < count_reg);
            hit[j]   = valid[j] && (pos_x_reg[j] == px_reg) && (pos_y_reg[j] == py_reg);
        end
    end

    assign hit_any  = |hit;
    assign hit_idx  = lowest_idx(hit);
    assign pend_idx = lowest_idx(pending_reg);
    assign seeds    = valid & ~marked_reg & ~visited_reg;
    assign seed_idx = lowest_idx(seeds);

    // single list read port
    always_comb begin
        if (cmd_in.bfs_step) rd_addr = pend_idx;
        else if (cmd_in.res_sel == RES_MEMBER) rd_addr = emit_idx_reg;
        else rd_addr = last_idx;
    end
    assign rd_x = pos_x_reg[rd_addr];
    assign rd_y = pos_y_reg[rd_addr];

    // link lanes: wrapped Chebyshev distance against the frontier entry
    always_comb begin
        logic [COORD_W-1:0] ax, ay;
        logic [DIM_W-1:0]   bx, by, dx, dy, dm;
        for (int j = 0; j < MAX_DEFECTS; j++) begin
            ax = (pos_x_reg[j] > rd_x) ? pos_x_reg[j] - rd_x : rd_x - pos_x_reg[j];
            ay = (pos_y_reg[j] > rd_y) ? pos_y_reg[j] - rd_y : rd_y - pos_y_reg[j];
            bx = eff_w - {1'b0, ax};
            by = eff_h - {1'b0, ay};
            dx = ({1'b0, ax} < bx) ? {1'b0, ax} : bx;
            dy = ({1'b0, ay} < by) ? {1'b0, ay} : by;
            dm = (dx > dy) ? dx : dy;
            near[j] = ({2'b00, dm} <= radius);
        end
    end

    // occupied columns and rows of the current cluster
    always_comb begin
        col_occ = '0;
        row_occ = '0;
        for (int j = 0; j < MAX_DEFECTS; j++) begin
            if (member_reg[j]) begin
                col_occ[pos_x_reg[j]] = 1'b1;
                row_occ[pos_y_reg[j]] = 1'b1;
            end
        end
    end

    // marks after a removal: the last entry's mark moves into the freed slot
    always_comb begin
        marks_removed = marked_reg;
        marks_removed[hit_idx] = marked_reg[last_idx];
        marks_removed[last_idx] = 1'b0;
    end

    always_comb begin
        count_after = count_reg;
        if (cmd_reg == CMD_TOGGLE && on_grid) begin
            if (hit_any) count_after = count_reg - CNT_W'(1);
            else if (!full) count_after = count_reg + CNT_W'(1);
        end else if (cmd_reg == CMD_CLEAR) begin
            count_after = '0;
        end
    end

    assign higher  = member_reg & ~((MAX_DEFECTS'(2) << emit_idx_reg) - MAX_DEFECTS'(1));
    assign cur_end = member_reg[emit_idx_reg] && (higher == '0);

    assign stat.is_cluster   = (cmd_reg == CMD_CLUSTER);
    assign stat.any_unmarked = |(valid & ~marked_reg);
    assign stat.any_seed     = |seeds;
    assign stat.any_pending  = |pending_reg;
    assign stat.scan_done    = (scan_c_reg == 5'd31);
    assign stat.cur_member   = member_reg[emit_idx_reg];
    assign stat.cur_end      = cur_end;

    always_comb begin
        res = '0;
        res.defect_count = count_reg;
        unique case (cmd_in.res_sel)
            RES_CMD: begin
                res.kind = (cmd_reg == CMD_TOGGLE && on_grid && !hit_any && full)
                           ? KIND_FULL : KIND_DONE;
                res.defect_count = count_after;
                res.last = 1'b1;
            end
            RES_EMPTY: begin
                res.kind = KIND_EMPTY;
                res.last = 1'b1;
            end
            RES_MEMBER: begin
                res.kind        = KIND_MEMBER;
                res.member_x    = rd_x;
                res.member_y    = rd_y;
                res.cluster_id  = cid_reg;
                res.cluster_end = cur_end;
                res.last        = cur_end && !(|seeds);
                if (cur_end) begin
                    res.rect_x = rect_x_reg;
                    res.rect_y = rect_y_reg;
                    res.rect_w = rect_w_reg;
                    res.rect_h = rect_h_reg;
                end
            end
            default: res = '0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg  <= DIM_W'(MAX_W);
            grid_h_reg  <= DIM_W'(MAX_H);
            count_reg   <= '0;
            marked_reg  <= '0;
            visited_reg <= '0;
            pending_reg <= '0;
        end else if (cfg_valid && (cfg_index == REG_GRID_W || cfg_index == REG_GRID_H)) begin
            if (cfg_index == REG_GRID_W) grid_w_reg <= cfg_data;
            else grid_h_reg <= cfg_data;
            count_reg  <= '0;
            marked_reg <= '0;
        end else begin
            if (cmd_in.apply) begin
                count_reg <= count_after;
                priority case (cmd_reg)
                    CMD_TOGGLE: begin
                        if (on_grid && !hit_any && !full) begin
                            marked_reg[count_reg[SLOT_W-1:0]] <= 1'b0;
                        end else if (on_grid && hit_any) begin
                            marked_reg <= marks_removed;
                        end
                    end
                    CMD_MARK:   if (on_grid && hit_any) marked_reg[hit_idx] <= 1'b1;
                    CMD_UNMARK: marked_reg <= '0;
                    CMD_CLEAR:  marked_reg <= '0;
                    default: ;
                endcase
            end
            if (cmd_in.q_clear) begin
                visited_reg <= '0;
                pending_reg <= '0;
            end
            if (cmd_in.seed) pending_reg <= MAX_DEFECTS'(1) << seed_idx;
            if (cmd_in.bfs_step) begin
                visited_reg[pend_idx] <= 1'b1;
                pending_reg <= (pending_reg | (near & seeds))
                               & ~(MAX_DEFECTS'(1) << pend_idx);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd_in.capture) begin
            cmd_reg <= in_data[2:0];
            px_reg  <= in_data[7:3];
            py_reg  <= in_data[12:8];
            lvl_reg <= in_data[15:13];
        end
        if (cmd_in.apply && cmd_reg == CMD_TOGGLE && on_grid) begin
            if (!hit_any && !full) begin
                pos_x_reg[count_reg[SLOT_W-1:0]] <= px_reg;
                pos_y_reg[count_reg[SLOT_W-1:0]] <= py_reg;
            end else if (hit_any && hit_idx != last_idx) begin
                pos_x_reg[hit_idx] <= rd_x;
                pos_y_reg[hit_idx] <= rd_y;
            end
        end
        if (cmd_in.q_clear) cid_reg <= '0;
        if (cmd_in.cid_inc) cid_reg <= cid_reg + 5'd1;
        if (cmd_in.seed) member_reg <= '0;
        if (cmd_in.bfs_step) member_reg[pend_idx] <= 1'b1;
        if (cmd_in.scan_start) begin
            occ_reg[0]   <= col_occ;
            occ_reg[1]   <= row_occ;
            scan_c_reg   <= '0;
            emit_idx_reg <= '0;
            for (int a = 0; a < 2; a++) begin
                fv_reg[a]   <= 1'b0;
                bgap_reg[a] <= '0;
            end
        end
        if (cmd_in.scan_step) begin
            scan_c_reg <= scan_c_reg + 5'd1;
            for (int a = 0; a < 2; a++) begin
                if (occ_reg[a][scan_c_reg]) begin
                    prev_reg[a] <= scan_c_reg;
                    if (!fv_reg[a]) begin
                        fv_reg[a]    <= 1'b1;
                        first_reg[a] <= scan_c_reg;
                    end else if (scan_c_reg - prev_reg[a] - 5'd1 > bgap_reg[a]) begin
                        bgap_reg[a]   <= scan_c_reg - prev_reg[a] - 5'd1;
                        bstart_reg[a] <= scan_c_reg;
                    end
                end
            end
        end
        if (cmd_in.rect_fin) begin
            begin
                logic [6:0] wrap_x, wrap_y;
                wrap_x = 7'(first_reg[0]) + 7'(eff_w) - 7'(prev_reg[0]) - 7'd1;
                wrap_y = 7'(first_reg[1]) + 7'(eff_h) - 7'(prev_reg[1]) - 7'd1;
                if (7'(bgap_reg[0]) > wrap_x) begin
                    rect_x_reg <= bstart_reg[0];
                    rect_w_reg <= eff_w - DIM_W'(bgap_reg[0]);
                end else begin
                    rect_x_reg <= first_reg[0];
                    rect_w_reg <= eff_w - wrap_x[DIM_W-1:0];
                end
                if (7'(bgap_reg[1]) > wrap_y) begin
                    rect_y_reg <= bstart_reg[1];
                    rect_h_reg <= eff_h - DIM_W'(bgap_reg[1]);
                end else begin
                    rect_y_reg <= first_reg[1];
                    rect_h_reg <= eff_h - wrap_y[DIM_W-1:0];
                end
            end
        end
        if (cmd_in.emit_step) emit_idx_reg <= emit_idx_reg + SLOT_W'(1);
    end

endmodule

FILE: verif/toric_defect_cluster_engine_test.sv
// Testbench for the toric defect cluster engine: directed and random requests
// checked against a behavioural predictor held in a small scoreboard class.
// Depends on tdce_pkg and the toric_defect_cluster_engine RTL.
`timescale 1ns / 100ps

module toric_defect_cluster_engine_test;
    import tdce_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] mx;
        logic [4:0] my;
        logic [4:0] cid;
        logic       cend;
        logic [4:0] rx;
        logic [4:0] ry;
        logic [5:0] rw;
        logic [5:0] rh;
        logic [5:0] cnt;
        logic       lst;
    } cluster_result_t;

    // Predictor of the defect list plus the queue of results still owed.
    class defect_scoreboard;
        int unsigned width_cfg, height_cfg;
        int   cell_slot[1024];
        int   slot_x[32], slot_y[32];
        bit   slot_mark[32];
        int   count;
        cluster_result_t owed[$];
        int   errors;

        function void owe(cluster_result_t r);
            owed.insert(owed.size(), r);
        endfunction

        function void wipe();
            foreach (cell_slot[i]) cell_slot[i] = 0;
            foreach (slot_mark[i]) slot_mark[i] = 0;
            count = 0;
        endfunction

        function void init();
            width_cfg = 32;
            height_cfg = 32;
            errors = 0;
            wipe();
        endfunction

        function void write_reg(int idx, int val);
            if (idx == REG_GRID_W) width_cfg = val;
            else if (idx == REG_GRID_H) height_cfg = val;
            else return;
            wipe();
        endfunction

        function int clampd(int v);
            if (v < 1) return 1;
            return v > 32 ? 32 : v;
        endfunction

        function int wdist(int a, int b, int n);
            int d;
            d = a > b ? a - b : b - a;
            return d < n - d ? d : n - d;
        endfunction

        function void span_of(bit [31:0] occ, int n, output int st, output int ln);
            int f, l, prev, gap;
            f = n; l = 0;
            for (int c = 0; c < n; c++)
                if (occ[c]) begin
                    if (f == n) f = c;
                    l = c;
                end
            if (f == n) begin st = 0; ln = 0; return; end
            if (f == l) begin st = f; ln = 1; return; end
            gap = f + n - l - 1;
            st = f;
            prev = f;
            for (int c = f + 1; c <= l; c++)
                if (occ[c]) begin
                    if (c - prev - 1 > gap) begin
                        gap = c - prev - 1;
                        st = c;
                    end
                    prev = c;
                end
            ln = n - gap;
        endfunction

        function cluster_result_t blank(logic [1:0] k);
            cluster_result_t r;
            r = '0;
            r.kind = k;
            r.cnt = 6'(count);
            return r;
        endfunction

        function string show(cluster_result_t r);
            string s;
            s = $sformatf("kind=%0d m=(%0d,%0d) cid=%0d end=%0d ",
                          r.kind, r.mx, r.my, r.cid, r.cend);
            s = {s, $sformatf("rect=(%0d,%0d,%0d,%0d) cnt=%0d last=%0d",
                              r.rx, r.ry, r.rw, r.rh, r.cnt, r.lst)};
            return s;
        endfunction

        function void note_request(logic [2:0] cmd, int px, int py, int lvl);
            int w, h, cell_ix, s, li, rad, nres, cid, seed, endslot, rx, ry, rw, rh;
            bit visited[32], pending[32], member[32], any;
            bit [31:0] cocc, rocc;
            cluster_result_t r;
            w = clampd(width_cfg);
            h = clampd(height_cfg);
            cell_ix = py * 32 + px;
            if (cmd == CMD_TOGGLE || cmd == CMD_MARK) begin
                r = blank(KIND_DONE);
                if (px < w && py < h) begin
                    s = cell_slot[cell_ix];
                    if (cmd == CMD_MARK) begin
                        if (s != 0) slot_mark[s-1] = 1;
                    end else if (s == 0) begin
                        if (count >= 32) r.kind = KIND_FULL;
                        else begin
                            slot_x[count] = px;
                            slot_y[count] = py;
                            slot_mark[count] = 0;
                            count++;
                            cell_slot[cell_ix] = count;
                        end
                    end else begin
                        li = count - 1;
                        cell_slot[cell_ix] = 0;
                        if (s - 1 != li) begin
                            slot_x[s-1] = slot_x[li];
                            slot_y[s-1] = slot_y[li];
                            slot_mark[s-1] = slot_mark[li];
                            cell_slot[slot_y[li] * 32 + slot_x[li]] = s;
                        end
                        slot_mark[li] = 0;
                        count--;
                    end
                end
                r.cnt = 6'(count);
                r.lst = 1;
                owe(r);
                return;
            end
            if (cmd == CMD_UNMARK) foreach (slot_mark[i]) slot_mark[i] = 0;
            if (cmd == CMD_CLEAR) wipe();
            if (cmd != CMD_CLUSTER) begin
                r = blank(KIND_DONE);
                r.lst = 1;
                owe(r);
                return;
            end
            rad = 1 << lvl;
            any = 0;
            for (int i = 0; i < 32; i++) begin
                visited[i] = 0;
                pending[i] = 0;
                if (i < count && !slot_mark[i]) any = 1;
            end
            if (!any) begin
                r = blank(KIND_EMPTY);
                r.lst = 1;
                owe(r);
                return;
            end
            nres = 0;
            cid = 0;
            forever begin
                seed = count;
                for (int i = count - 1; i >= 0; i--)
                    if (!slot_mark[i] && !visited[i]) seed = i;
                if (seed == count || nres >= 32) break;
                foreach (member[i]) member[i] = 0;
                pending[seed] = 1;
                any = 1;
                while (any) begin
                    any = 0;
                    for (int i = 0; i < count; i++) begin
                        if (!pending[i]) continue;
                        any = 1;
                        pending[i] = 0;
                        visited[i] = 1;
                        member[i] = 1;
                        for (int j = 0; j < count; j++) begin
                            int dx, dy;
                            if (visited[j] || slot_mark[j] || pending[j]) continue;
                            dx = wdist(slot_x[i], slot_x[j], w);
                            dy = wdist(slot_y[i], slot_y[j], h);
                            if ((dx > dy ? dx : dy) <= rad) pending[j] = 1;
                        end
                        break;
                    end
                end
                cocc = 0;
                rocc = 0;
                endslot = 0;
                for (int i = 0; i < count; i++)
                    if (member[i]) begin
                        cocc[slot_x[i]] = 1;
                        rocc[slot_y[i]] = 1;
                        endslot = i;
                    end
                span_of(cocc, w, rx, rw);
                span_of(rocc, h, ry, rh);
                for (int i = 0; i < count && nres < 32; i++) begin
                    if (!member[i]) continue;
                    r = blank(KIND_MEMBER);
                    r.mx = 5'(slot_x[i]);
                    r.my = 5'(slot_y[i]);
                    r.cid = 5'(cid);
                    if (i == endslot) begin
                        r.cend = 1;
                        r.rx = 5'(rx);
                        r.ry = 5'(ry);
                        r.rw = 6'(rw);
                        r.rh = 6'(rh);
                    end
                    owe(r);
                    nres++;
                end
                cid++;
            end
            owed[owed.size() - 1].lst = 1;
        endfunction

        function void check_result(cluster_result_t got);
            cluster_result_t e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result kind=%0d", $time, got.kind);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got !== e) begin
                $display("%0t: mismatch expected %s actual %s", $time, show(e), show(got));
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]   cfg_data;

    defect_scoreboard sb;
    int  idle_cycles = 0;
    int  hold_request;   // sender asks the receiver to hold off this many cycles
    bit  sink_quiet;     // receiver stalls only on request

    toric_defect_cluster_engine dut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Short gaps mostly, now and then a long one.
    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: sample at rising edge, stall at the falling edge.
    always @(posedge aclk) begin
        cluster_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.mx   = m_tdata[4:0];
            got.my   = m_tdata[9:5];
            got.cid  = m_tdata[14:10];
            got.cend = m_tdata[15];
            got.rx   = m_tdata[20:16];
            got.ry   = m_tdata[25:21];
            got.rw   = m_tdata[31:26];
            got.rh   = m_tdata[37:32];
            got.cnt  = m_tdata[43:38];
            got.lst  = m_tlast;
            sb.check_result(got);
        end
    end

    initial begin : sink
        int g;
        bit held;
        held = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request > 0 && !held) begin
                // long hold-off, counted here
                held = 1;
                g = hold_request;
                m_tready <= 1'b0;
                repeat (g) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (sink_quiet) begin
                m_tready <= 1'b1;
            end else begin
                g = gap_len();
                if (g == 0) m_tready <= 1'b1;
                else begin
                    m_tready <= 1'b0;
                    repeat (g - 1) @(negedge aclk);
                    @(negedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: cycles with no handshake anywhere.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] cmd, int px, int py, int lvl, bit gaps);
        int g;
        if (gaps) begin
            g = gap_len();
            repeat (g) @(negedge aclk);
        end
        s_tdata  <= {lvl[2:0], py[4:0], px[4:0], cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, px, py, lvl);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (sb.owed.size() != 0) @(negedge aclk);
        // a request with no pending result may still be finishing
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_index <= idx;
        cfg_data  <= val[5:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Random request, weighted towards toggles on a small live set.
    task automatic random_request(int w, int h);
        int p, px, py;
        p = $urandom_range(0, 99);
        px = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, w - 1);
        py = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, h - 1);
        if (p < 55) send_request(CMD_TOGGLE, px, py, $urandom_range(0, 7), 1);
        else if (p < 70) send_request(CMD_MARK, px, py, $urandom_range(0, 7), 1);
        else if (p < 74) send_request(CMD_UNMARK, px, py, 0, 1);
        else if (p < 76) send_request(CMD_CLEAR, px, py, 0, 1);
        else if (p < 78) send_request(3'($urandom_range(5, 7)), px, py, 0, 1);
        else send_request(CMD_CLUSTER, px, py, $urandom_range(0, 7), 1);
    endtask

    initial begin : stimulus
        int dims[6][2];
        sb = new();
        sb.init();
        hold_request = 0;
        sink_quiet = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, wrap, empty query, marks, off-grid, unknown codes.
        send_request(CMD_CLUSTER, 0, 0, 0, 0);
        send_request(CMD_TOGGLE, 0, 0, 0, 0);
        send_request(CMD_TOGGLE, 31, 31, 0, 0);
        send_request(CMD_TOGGLE, 31, 0, 0, 0);
        send_request(CMD_TOGGLE, 5, 17, 0, 0);
        send_request(CMD_CLUSTER, 0, 0, 0, 0);
        send_request(CMD_MARK, 5, 17, 0, 0);
        send_request(CMD_MARK, 5, 17, 0, 0);
        send_request(CMD_MARK, 9, 9, 0, 0);
        send_request(CMD_TOGGLE, 0, 0, 0, 0);
        send_request(CMD_CLUSTER, 0, 0, 5, 0);
        send_request(CMD_CLUSTER, 0, 0, 7, 0);
        send_request(CMD_UNMARK, 0, 0, 0, 0);
        send_request(CMD_CLUSTER, 31, 31, 2, 0);
        send_request(3'd7, 31, 31, 7, 0);
        send_request(3'd5, 0, 0, 0, 0);
        drain();
        write_reg(REG_GRID_W, 10);
        write_reg(REG_GRID_H, 0);
        send_request(CMD_TOGGLE, 12, 0, 0, 0);
        send_request(CMD_TOGGLE, 9, 0, 0, 0);
        send_request(CMD_TOGGLE, 0, 0, 0, 0);
        send_request(CMD_CLUSTER, 0, 0, 0, 0);
        send_request(CMD_CLEAR, 0, 0, 0, 0);
        send_request(CMD_CLUSTER, 0, 0, 1, 0);
        drain();

        // Fill to capacity under a long receiver hold-off, then overflow.
        write_reg(REG_GRID_W, 63);
        write_reg(REG_GRID_H, 32);
        hold_request = 200;
        for (int i = 0; i < 32; i++) send_request(CMD_TOGGLE, i, (i * 7) % 32, 0, 0);
        send_request(CMD_TOGGLE, 0, 1, 0, 0);
        send_request(CMD_CLUSTER, 0, 0, 0, 0);
        send_request(CMD_CLUSTER, 0, 0, 5, 0);
        drain();   // sender pauses until every result is in

        dims = '{'{32, 32}, '{1, 1}, '{2, 5}, '{7, 3}, '{32, 1}, '{13, 32}};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_GRID_W, dims[ph][0]);
            write_reg(REG_GRID_H, dims[ph][1]);
            sink_quiet = (ph == 3);
            for (int n = 0; n < 35; n++) random_request(dims[ph][0], dims[ph][1]);
            drain();
        end

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
